// ----- src/overdraw_count_statistics_defines.svh -----
// ----------------------------------------------------------------------------
// Overdraw count statistics: assertion macros
// Shared property forms for the checker; both sample on clk and are
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef OVERDRAW_COUNT_STATISTICS_DEFINES_SVH
`define OVERDRAW_COUNT_STATISTICS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ODCS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("overdraw statistics check failed");

// The consequent must hold in the cycle after the antecedent.
`define ODCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("overdraw statistics check failed");

`endif

// ----- src/odcs_pkg.sv -----
// ----------------------------------------------------------------------------
// Overdraw count statistics package
// Widths, limits, bucket codes and the bucket selection function shared by
// the converter, the top level and the checker.
// ----------------------------------------------------------------------------
package odcs_pkg;

  // Field widths.
  localparam int HALF_W      = 16;
  localparam int COUNT_W     = 16;
  localparam int SUM_W       = 40;
  localparam int CNT_W       = 25;
  localparam int NUM_BUCKETS = 8;
  localparam int BKT_IDX_W   = 3;
  localparam int OUT_DATA_W  = 304;
  localparam int OUT_USED_W  = COUNT_W + SUM_W + CNT_W + COUNT_W + NUM_BUCKETS * CNT_W;

  // Pixel counter limit: the smaller of the image size and the field range.
  localparam longint MAX_PIXELS    = 16777216;
  localparam longint CNT_FIELD_MAX = (64'd1 << CNT_W) - 1;
  localparam logic [CNT_W-1:0] CNT_CAP =
    CNT_W'((MAX_PIXELS < CNT_FIELD_MAX) ? MAX_PIXELS : CNT_FIELD_MAX);
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Largest count a finite binary16 word can produce.
  localparam logic [COUNT_W-1:0] COUNT_FINITE_MAX = 16'd65504;

  // Exponent landmarks of binary16 for the integer conversion.
  localparam logic [4:0] EXP_SPECIAL    = 5'd31;
  localparam logic [4:0] EXP_INT_SHIFT  = 5'd25;
  localparam logic [4:0] EXP_MIN_ROUND  = 5'd14;

  // Histogram bucket codes.
  localparam logic [BKT_IDX_W-1:0] BKT_ONE     = 3'd0;
  localparam logic [BKT_IDX_W-1:0] BKT_TWO     = 3'd1;
  localparam logic [BKT_IDX_W-1:0] BKT_THREE   = 3'd2;
  localparam logic [BKT_IDX_W-1:0] BKT_FOUR    = 3'd3;
  localparam logic [BKT_IDX_W-1:0] BKT_UPTO8   = 3'd4;
  localparam logic [BKT_IDX_W-1:0] BKT_UPTO16  = 3'd5;
  localparam logic [BKT_IDX_W-1:0] BKT_UPTO32  = 3'd6;
  localparam logic [BKT_IDX_W-1:0] BKT_ABOVE   = 3'd7;

  // Select the histogram bucket of a nonzero count.
  function automatic logic [BKT_IDX_W-1:0] bucket_of(input logic [COUNT_W-1:0] n);
    logic [BKT_IDX_W-1:0] b;
    if (n == 16'd1) begin
      b = BKT_ONE;
    end else if (n == 16'd2) begin
      b = BKT_TWO;
    end else if (n == 16'd3) begin
      b = BKT_THREE;
    end else if (n == 16'd4) begin
      b = BKT_FOUR;
    end else if (n <= 16'd8) begin
      b = BKT_UPTO8;
    end else if (n <= 16'd16) begin
      b = BKT_UPTO16;
    end else if (n <= 16'd32) begin
      b = BKT_UPTO32;
    end else begin
      b = BKT_ABOVE;
    end
    return b;
  endfunction

endpackage

// ----- src/odcs_half_conv.sv -----
// ----------------------------------------------------------------------------
// Overdraw count statistics: binary16 to count converter
// Rounds a binary16 word half away from zero to an unsigned count; words
// that are negative, non-finite or below one half give zero.
// ----------------------------------------------------------------------------
module odcs_half_conv
  import odcs_pkg::*;
(
  input  logic [HALF_W-1:0]  half_bits,
  output logic [COUNT_W-1:0] count
);

  logic             sign;
  logic [4:0]       expo;
  logic [10:0]      sig;
  logic [16:0]      sig_ext;
  logic [4:0]       up_amt;
  logic [4:0]       dn_amt;
  logic [16:0]      up_val;
  logic [16:0]      dn_val;
  logic [16:0]      wide;

  assign sign    = half_bits[15];
  assign expo    = half_bits[14:10];
  assign sig     = {1'b1, half_bits[9:0]};
  assign sig_ext = {6'd0, sig};

  // Shift amounts relative to the integer point of the significand.
  assign up_amt = expo - EXP_INT_SHIFT;
  assign dn_amt = EXP_INT_SHIFT - expo;

  // Large exponents shift left exactly; smaller ones add a half and shift right.
  assign up_val = sig_ext << up_amt[2:0];
  assign dn_val = (sig_ext + (17'd1 << (dn_amt[3:0] - 4'd1))) >> dn_amt[3:0];

  always_comb begin
    if (sign || expo == EXP_SPECIAL || expo < EXP_MIN_ROUND) begin
      wide = '0;
    end else if (expo >= EXP_INT_SHIFT) begin
      wide = up_val;
    end else begin
      wide = dn_val;
    end
  end

  // Clamp to the count range.
  assign count = wide[16] ? COUNT_MAX : wide[COUNT_W-1:0];

endmodule

// ----- src/overdraw_count_statistics.sv -----
// ----------------------------------------------------------------------------
// Overdraw count statistics
// Converts per-pixel binary16 overdraw counts and keeps running image
// statistics: fragment sum, covered pixels, maximum and an 8-bucket histogram.
// ----------------------------------------------------------------------------
// The block takes one pixel word per cycle, while results are taken, and
// returns one result per pixel. The word is captured in the input register
// at the accepting edge, and its result loads the result register when
// that register is empty or being taken. The accumulators are
// updated in the same cycle that the result register loads, so one pixel per
// cycle is sustained as long as results are taken; while the result waits,
// one more pixel may still enter the input register. A pixel sent with
// in_tlast high gets a result that includes it, and the statistics restart
// from zero with the next pixel. Counters saturate instead of wrapping.
module overdraw_count_statistics
  import odcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [HALF_W-1:0]     in_tdata,   // [15:0] half_bits
  input  logic                  in_tlast,   // last_of_image
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_tdata, from bit 0: pixel_count, fragment_total, covered_total,
  // max_seen, bucket_one, bucket_two, bucket_three, bucket_four,
  // bucket_upto_eight, bucket_upto_sixteen, bucket_upto_thirtytwo,
  // bucket_above, zero padding
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic                  in_valid_r;
  logic [HALF_W-1:0]     in_half_r;
  logic                  in_last_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;

  logic [SUM_W-1:0]      sum_r;
  logic [CNT_W-1:0]      covered_r;
  logic [COUNT_W-1:0]    max_r;
  logic [CNT_W-1:0]      bucket_r [NUM_BUCKETS];
  logic [SUM_W-1:0]      sum_nxt;
  logic [CNT_W-1:0]      covered_nxt;
  logic [COUNT_W-1:0]    max_nxt;
  logic [CNT_W-1:0]      bucket_nxt [NUM_BUCKETS];

  logic                  advance;
  logic                  in_fire;
  logic [COUNT_W-1:0]    count;
  logic                  nonzero;
  logic [BKT_IDX_W-1:0]  bkt;
  logic [SUM_W:0]        sum_wide;
  logic [CNT_W*NUM_BUCKETS-1:0] bucket_flat;

  // Handshake: the result register frees when empty or being taken.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_half_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // Conversion of the registered word.
  odcs_half_conv u_conv (
    .half_bits (in_half_r),
    .count     (count)
  );

  assign nonzero  = count != '0;
  assign bkt      = bucket_of(count);
  assign sum_wide = {1'b0, sum_r} + {{(SUM_W + 1 - COUNT_W){1'b0}}, count};

  // Statistics including this pixel.
  always_comb begin
    sum_nxt     = sum_r;
    covered_nxt = covered_r;
    max_nxt     = max_r;
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      bucket_nxt[i] = bucket_r[i];
    end
    if (nonzero) begin
      sum_nxt     = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
      covered_nxt = (covered_r >= CNT_CAP) ? CNT_CAP : covered_r + 1'b1;
      max_nxt     = (count > max_r) ? count : max_r;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        if (bkt == BKT_IDX_W'(i)) begin
          bucket_nxt[i] = (bucket_r[i] >= CNT_CAP) ? CNT_CAP : bucket_r[i] + 1'b1;
        end
      end
    end
  end

  // Pack the result word.
  always_comb begin
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      bucket_flat[i*CNT_W +: CNT_W] = bucket_nxt[i];
    end
    out_data_nxt = {{(OUT_DATA_W - OUT_USED_W){1'b0}},
                    bucket_flat, max_nxt, covered_nxt, sum_nxt, count};
  end

  // Accumulators: load the updated values, or clear after the last pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      covered_r <= '0;
      max_r     <= '0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        bucket_r[i] <= '0;
      end
    end else if (advance) begin
      if (in_last_r) begin
        sum_r     <= '0;
        covered_r <= '0;
        max_r     <= '0;
        for (int i = 0; i < NUM_BUCKETS; i++) begin
          bucket_r[i] <= '0;
        end
      end else begin
        sum_r     <= sum_nxt;
        covered_r <= covered_nxt;
        max_r     <= max_nxt;
        for (int i = 0; i < NUM_BUCKETS; i++) begin
          bucket_r[i] <= bucket_nxt[i];
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- src/odcs_checker.sv -----
// ----------------------------------------------------------------------------
// Overdraw count statistics: port checker
// Watches the top level's ports and checks the result stream over time.
// ----------------------------------------------------------------------------
`include "overdraw_count_statistics_defines.svh"

module odcs_checker
  import odcs_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [HALF_W-1:0]     in_tdata,
  input logic                  in_tlast,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic [COUNT_W-1:0] pix;
  logic [SUM_W-1:0]   frag;
  logic [CNT_W-1:0]   cov;
  logic [COUNT_W-1:0] mx;

  assign pix  = out_tdata[COUNT_W-1:0];
  assign frag = out_tdata[COUNT_W +: SUM_W];
  assign cov  = out_tdata[COUNT_W + SUM_W +: CNT_W];
  assign mx   = out_tdata[COUNT_W + SUM_W + CNT_W +: COUNT_W];

  // An accepted request carries defined contents.
  `ODCS_ASSERT_SAME(a_in_known, in_tvalid && in_tready, !$isunknown({in_tdata, in_tlast}))

  // A held result keeps its contents until taken.
  `ODCS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // A finite binary16 word never rounds above its largest value.
  `ODCS_ASSERT_SAME(a_pix_range, out_tvalid, pix <= COUNT_FINITE_MAX)

  // The image maximum covers the current pixel.
  `ODCS_ASSERT_SAME(a_max_covers, out_tvalid, mx >= pix)

  // Every covered pixel adds at least one fragment, and the count saturates.
  `ODCS_ASSERT_SAME(a_cov_bound, out_tvalid,
                    cov <= CNT_CAP && {{(SUM_W - CNT_W){1'b0}}, cov} <= frag)

endmodule

bind overdraw_count_statistics odcs_checker u_odcs_checker (.*);
